// File: hw/rtl/mlev_pkg.sv
// Shared types and constants for the mixing-length eddy viscosity core.
// No dependencies; imported by the core and its checker.
`default_nettype none
package mlev_pkg;

	localparam int SQRT_STEPS = 34;  // root bits of a 67-bit radicand
	localparam int FDIV_STEPS = 31;  // quotient bits of (1-2y/h) in Q1.30
	localparam int QDIV_STEPS = 32;  // quotient bits of nu/(Cmu*y)
	localparam int MUL_STAGES = 6;
	localparam int PIPE_DEPTH = 3 + SQRT_STEPS + MUL_STAGES + 1 + QDIV_STEPS + 2;

	localparam logic [29:0] K2_Q032 = 30'd739700743;  // 0.415^2 in Q0.32
	localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

	localparam logic [31:0] RST_BOTTOM = 32'd0;
	localparam logic [31:0] RST_TOP    = 32'd131072;
	localparam logic [15:0] RST_CMU    = 16'd5898;
	localparam logic [1:0]  RST_DIMS   = 2'd3;

	typedef enum logic [1:0] {
		REG_BOTTOM = 2'd0,
		REG_TOP    = 2'd1,
		REG_CMU    = 2'd2,
		REG_DIMS   = 2'd3
	} cfg_reg_t;

	// per-cell context carried down the pipe
	typedef struct packed {
		logic [31:0] y;
		logic        outside;
		logic        hz;
		logic        yz;
		logic [47:0] dcap;
	} ctx_t;

	// square root and (1-2y/h) divider, one bit each per stage (divider: first FDIV_STEPS stages only)
	typedef struct packed {
		ctx_t        c;
		logic [31:0] h;
		logic [67:0] rad;
		logic [35:0] srem;
		logic [33:0] root;
		logic [32:0] drem;
		logic [30:0] quot;
	} iter_t;

	// nu/(Cmu*y) divider
	typedef struct packed {
		logic        yz;
		logic        qsat;
		logic        sat;
		logic [30:0] nu;
		logic [47:0] dcap;
		logic [47:0] rem;
		logic [31:0] quot;
	} qdiv_t;

endpackage
`default_nettype wire

// File: hw/rtl/mixing_length_eddy_viscosity_core.sv
// Mixing-length eddy viscosity core: strain norm, wall distance, nu_t and k.
// Depends on mlev_pkg.
// One word per cycle while the output is not stalled.
// The 34-step square root and the two restoring dividers (31 and 32 steps)
// are unrolled into stages; the whole pipe advances together and holds on
// a stalled output. arst_n clears valid bits and sets the config registers to defaults.
`default_nettype none
module mixing_length_eddy_viscosity_core #(
	parameter int MAX_DIMS = 3
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// normal_coord, grad_xx, xy, xz, yx, yy, yz, zx, zy, zz (32 bits each)
	input  wire logic [319:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// eddy_viscosity [30:0], turb_energy [61:31], zero pad [63:62]
	output logic [63:0]       m_tdata,
	// zero_distance [0], saturated [1]
	output logic [1:0]        m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import mlev_pkg::*;

	logic [31:0] bottom_q, top_q;
	logic [15:0] cmu_q;
	logic [1:0]  dims_q;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic en;

	function automatic logic [32:0] abs33(input logic [32:0] v);
		abs33 = v[32] ? (~v + 33'd1) : v;
	endfunction

	// magnitude that is known to fit 32 bits
	function automatic logic [31:0] abs32(input logic [32:0] v);
		logic [32:0] a;
		a = abs33(v);
		abs32 = a[31:0];
	endfunction

	assign en       = ~vld_q[PIPE_DEPTH-1] | m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= RST_BOTTOM;
			top_q    <= RST_TOP;
			cmu_q    <= RST_CMU;
			dims_q   <= RST_DIMS;
			vld_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_BOTTOM: bottom_q <= cfg_data;
					REG_TOP:    top_q    <= cfg_data;
					REG_CMU:    cmu_q    <= cfg_data[15:0];
					REG_DIMS:   dims_q   <= cfg_data[1:0];
				endcase
			end
			if (en)
				vld_q <= {vld_q[PIPE_DEPTH-2:0], s_tvalid};
		end
	end

	// ---------------- stage 1: abs values, channel geometry
	logic [31:0] g [0:8];
	logic [31:0] crd;
	logic        use_z;
	logic [32:0] h_diff, y_diff;
	for (genvar k = 0; k < 9; k++) begin : g_fld
		assign g[k] = s_tdata[32*(k+1) +: 32];
	end
	assign crd    = s_tdata[31:0];
	assign use_z  = (MAX_DIMS > 2) && (dims_q == 2'd3);
	assign h_diff = {top_q[31], top_q} - {bottom_q[31], bottom_q};
	assign y_diff = {crd[31], crd} - {bottom_q[31], bottom_q};

	logic [31:0] d0_s1, d1_s1, d2_s1, h_s1, y0_s1;
	logic [32:0] o0_s1, o1_s1, o2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d0_s1 <= abs32({g[0][31], g[0]});
			d1_s1 <= abs32({g[4][31], g[4]});
			d2_s1 <= use_z ? abs32({g[8][31], g[8]}) : 32'd0;
			o0_s1 <= abs33({g[1][31], g[1]} + {g[3][31], g[3]});
			o1_s1 <= use_z ? abs33({g[2][31], g[2]} + {g[6][31], g[6]}) : 33'd0;
			o2_s1 <= use_z ? abs33({g[5][31], g[5]} + {g[7][31], g[7]}) : 33'd0;
			h_s1  <= abs32(h_diff);
			y0_s1 <= abs32(y_diff);
		end
	end

	// ---------------- stage 2: squares, fold into the lower half
	logic [63:0] sd0_s2, sd1_s2, sd2_s2;
	logic [65:0] so0_s2, so1_s2, so2_s2;
	logic [31:0] h_s2, y_s2;
	logic [31:0] y_fold;
	assign y_fold = ({y0_s1, 1'b0} > {1'b0, h_s1})
		? ((y0_s1 >= h_s1) ? (y0_s1 - h_s1) : (h_s1 - y0_s1)) : y0_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sd0_s2 <= 64'(d0_s1) * 64'(d0_s1);
			sd1_s2 <= 64'(d1_s1) * 64'(d1_s1);
			sd2_s2 <= 64'(d2_s1) * 64'(d2_s1);
			so0_s2 <= 66'(o0_s1) * 66'(o0_s1);
			so1_s2 <= 66'(o1_s1) * 66'(o1_s1);
			so2_s2 <= 66'(o2_s1) * 66'(o2_s1);
			h_s2   <= h_s1;
			y_s2   <= y_fold;
		end
	end

	// ---------------- stage 3 (iter_s[0]): strain sum, divider setup
	iter_t iter_s  [0:SQRT_STEPS];
	iter_t iter_nx [0:SQRT_STEPS];
	logic [66:0] v_sum;
	logic        outside3;
	assign v_sum = ((67'(sd0_s2) + 67'(sd1_s2) + 67'(sd2_s2)) << 1)
		+ 67'(so0_s2) + 67'(so1_s2) + 67'(so2_s2);
	assign outside3 = {y_s2, 1'b0} > {1'b0, h_s2};

	always_comb begin
		iter_nx[0].c.y       = y_s2;
		iter_nx[0].c.outside = outside3;
		iter_nx[0].c.hz      = (h_s2 == 32'd0);
		iter_nx[0].c.yz      = (y_s2 == 32'd0);
		iter_nx[0].c.dcap    = 48'(cmu_q) * 48'(y_s2);
		iter_nx[0].h         = h_s2;
		iter_nx[0].rad       = {1'b0, v_sum};
		iter_nx[0].srem      = '0;
		iter_nx[0].root      = '0;
		iter_nx[0].drem      = outside3 ? 33'd0 : {1'b0, h_s2 - {y_s2[30:0], 1'b0}};
		iter_nx[0].quot      = '0;
	end

	// ---------------- stages 4..37: one root bit each, plus one quotient bit in each of the first FDIV_STEPS
	for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_iter
		logic [37:0] cur;
		logic [35:0] trial;
		logic        rbit, dbit;
		logic [31:0] dsub;
		assign cur   = {iter_s[gi].srem, iter_s[gi].rad[67:66]};
		assign trial = {iter_s[gi].root, 2'b01};
		assign rbit  = cur >= {2'b00, trial};
		assign dbit  = iter_s[gi].drem >= {1'b0, iter_s[gi].h};
		assign dsub  = dbit ? (iter_s[gi].drem[31:0] - iter_s[gi].h) : iter_s[gi].drem[31:0];

		always_comb begin
			iter_nx[gi+1]      = iter_s[gi];
			iter_nx[gi+1].rad  = {iter_s[gi].rad[65:0], 2'b00};
			iter_nx[gi+1].srem = rbit ? 36'(cur - {2'b00, trial}) : cur[35:0];
			iter_nx[gi+1].root = {iter_s[gi].root[32:0], rbit};
			if (gi < FDIV_STEPS) begin
				iter_nx[gi+1].drem = {dsub, 1'b0};
				iter_nx[gi+1].quot = {iter_s[gi].quot[29:0], dbit};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= SQRT_STEPS; k++)
				iter_s[k] <= iter_nx[k];
		end
	end

	// ---------------- stages 38..43: M = y^2*F, L = M*K2, L*R
	ctx_t c_s38, c_s39, c_s40, c_s41, c_s42, c_s43;
	logic [33:0] r_s38, r_s39, r_s40, r_s41, r_s42, r_s43;
	logic [61:0] p1_s38, pa_s39, pb_s39, ka_s41;
	logic [60:0] kb_s41, l_s42;
	logic [62:0] m_s40;
	logic [64:0] ea_s43;
	logic [63:0] eb_s43;
	logic [92:0] m_sum;
	logic [93:0] l_sum;
	assign m_sum = 93'(pa_s39) + (93'(pb_s39) << 31);
	assign l_sum = 94'(ka_s41) + (94'(kb_s41) << 32);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s38  <= iter_s[SQRT_STEPS].c;
			r_s38  <= iter_s[SQRT_STEPS].root;
			p1_s38 <= 62'(iter_s[SQRT_STEPS].c.y[30:0]) * 62'(iter_s[SQRT_STEPS].quot);
			c_s39  <= c_s38;
			r_s39  <= r_s38;
			pa_s39 <= 62'(p1_s38[30:0]) * 62'(c_s38.y[30:0]);
			pb_s39 <= 62'(p1_s38[61:31]) * 62'(c_s38.y[30:0]);
			c_s40  <= c_s39;
			r_s40  <= r_s39;
			m_s40  <= m_sum[92:30];
			c_s41  <= c_s40;
			r_s41  <= r_s40;
			ka_s41 <= 62'(m_s40[31:0]) * 62'(K2_Q032);
			kb_s41 <= 61'(m_s40[62:32]) * 61'(K2_Q032);
			c_s42  <= c_s41;
			r_s42  <= r_s41;
			l_s42  <= l_sum[92:32];
			c_s43  <= c_s42;
			r_s43  <= r_s42;
			ea_s43 <= 65'(l_s42[30:0]) * 65'(r_s42);
			eb_s43 <= 64'(l_s42[60:31]) * 64'(r_s42);
		end
	end

	// ---------------- stage 44 (qd_s[0]): nu_t with clipping, divider setup
	qdiv_t qd_s  [0:QDIV_STEPS];
	qdiv_t qd_nx [0:QDIV_STEPS];
	logic [94:0] nu_prod;
	assign nu_prod = 95'(ea_s43) + (95'(eb_s43) << 31);

	always_comb begin
		logic [30:0] nu;
		logic        sat;
		nu  = '0;
		sat = 1'b0;
		if (c_s43.hz) begin
			nu  = '0;
		end else if (c_s43.outside) begin
			sat = (r_s43 != 34'd0);
		end else if (nu_prod[94:63] != 32'd0) begin
			nu  = OUT_MAX;
			sat = 1'b1;
		end else begin
			nu  = nu_prod[62:32];
		end
		qd_nx[0].yz   = c_s43.yz;
		qd_nx[0].qsat = 48'(nu) >= c_s43.dcap;  // quotient would pass 32 bits
		qd_nx[0].sat  = sat;
		qd_nx[0].nu   = nu;
		qd_nx[0].dcap = c_s43.dcap;
		qd_nx[0].rem  = 48'(nu);
		qd_nx[0].quot = '0;
	end

	// ---------------- stages 45..76: q = nu*2^32/(Cmu*y), one bit per stage
	for (genvar gq = 0; gq < QDIV_STEPS; gq++) begin : g_qdiv
		logic [48:0] sh;
		logic        qbit;
		assign sh   = {qd_s[gq].rem, 1'b0};
		assign qbit = sh >= {1'b0, qd_s[gq].dcap};
		always_comb begin
			qd_nx[gq+1]      = qd_s[gq];
			qd_nx[gq+1].rem  = qbit ? 48'(sh - {1'b0, qd_s[gq].dcap}) : sh[47:0];
			qd_nx[gq+1].quot = {qd_s[gq].quot[30:0], qbit};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= QDIV_STEPS; k++)
				qd_s[k] <= qd_nx[k];
		end
	end

	// ---------------- stages 77, 78: k = q^2/2^16 and output word
	logic [63:0] qsq_s77;
	logic        yz_s77, qsat_s77, sat_s77;
	logic [30:0] nu_s77;
	logic [30:0] nu_s78, ke_s78;
	logic        zero_s78, sat_s78;

	always_ff @(posedge clk) begin
		if (en) begin
			qsq_s77  <= 64'(qd_s[QDIV_STEPS].quot) * 64'(qd_s[QDIV_STEPS].quot);
			yz_s77   <= qd_s[QDIV_STEPS].yz;
			qsat_s77 <= qd_s[QDIV_STEPS].qsat;
			sat_s77  <= qd_s[QDIV_STEPS].sat;
			nu_s77   <= qd_s[QDIV_STEPS].nu;

			nu_s78   <= nu_s77;
			zero_s78 <= yz_s77;
			priority if (yz_s77) begin
				ke_s78  <= OUT_MAX;
				sat_s78 <= sat_s77;
			end else if (qsat_s77 || (qsq_s77[63:47] != 17'd0)) begin
				ke_s78  <= OUT_MAX;
				sat_s78 <= 1'b1;
			end else begin
				ke_s78  <= qsq_s77[46:16];
				sat_s78 <= sat_s77;
			end
		end
	end

	assign m_tdata = {2'b00, ke_s78, nu_s78};
	assign m_tuser = {sat_s78, zero_s78};

endmodule
`default_nettype wire

// File: hw/rtl/mlev_checker.sv
// Port-level checks for the mixing-length eddy viscosity core.
// Depends on mlev_pkg; bound onto mixing_length_eddy_viscosity_core.
`default_nettype none
module mlev_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import mlev_pkg::*;

	// output word holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed under stall");

	// whole pipe advances together
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// zero wall distance: no viscosity, energy pinned to max
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[30:0] == 31'd0 && m_tdata[61:31] == OUT_MAX)
		else $error("zero distance word has wrong values");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:62] == 2'b00)
		else $error("pad bits set");

	a_rst: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("word valid out of reset");

endmodule

bind mixing_length_eddy_viscosity_core mlev_checker u_mlev_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
